@@ rtl/core/esfp_pkg.sv @@
// Shared types and constants of the environment sensor frame parser.
package esfp_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h5A;
    localparam logic [7:0] TYPE_LIGHT = 8'h15;
    localparam logic [7:0] TYPE_ENV   = 8'h45;

    // Byte positions inside a frame, counted from zero.
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_HDR1       = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR2       = 4'd1;
    localparam logic [POS_W-1:0] POS_TYPE       = 4'd2;
    localparam logic [POS_W-1:0] POS_DATA_FIRST = 4'd4;
    localparam logic [POS_W-1:0] POS_DATA_LAST  = 4'd13;
    localparam logic [POS_W-1:0] POS_LIGHT_SUM  = 4'd8;
    localparam logic [POS_W-1:0] POS_ENV_SUM    = 4'd14;

    localparam int DATA_BYTES = 10;
    localparam int DATA_IDX_W = $clog2(DATA_BYTES);

    localparam logic KIND_LIGHT = 1'b0;
    localparam logic KIND_ENV   = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One checked frame as it travels from the front to the back.
    // data[0] holds frame byte 4, data[9] holds frame byte 13.
    typedef struct packed {
        logic                       kind;
        logic [DATA_BYTES-1:0][7:0] data;
    } frame_rec_t;

    // Status of the frame queue as seen by its neighbors.
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

@@ rtl/core/esfp_front.sv @@
// Front part: byte capture, header and type checks, running checksum.
module esfp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  logic [7:0]          rx_byte,
    input  esfp_pkg::q_status_t q_status,
    output logic                push,
    output esfp_pkg::frame_rec_t push_rec
);

    logic [esfp_pkg::POS_W-1:0] count_reg;
    logic [esfp_pkg::POS_W-1:0] count_next;
    logic [7:0]                 sum_reg;
    logic [7:0]                 sum_next;
    logic [7:0]                 byte0_reg;
    logic [7:0]                 type_reg;
    logic [7:0]                 data_reg [esfp_pkg::DATA_BYTES];

    logic                       accept;
    logic                       hdr_bad;
    logic                       light_end;
    logic                       env_end;
    logic                       in_data;
    logic [esfp_pkg::POS_W-1:0] data_off;
    logic [esfp_pkg::DATA_IDX_W-1:0] data_idx;

    assign rx_stall = q_status.full;
    assign accept   = rx_valid && !rx_stall;

    assign hdr_bad   = (count_reg == esfp_pkg::POS_HDR2) &&
                       ((byte0_reg != esfp_pkg::HDR_BYTE) || (rx_byte != esfp_pkg::HDR_BYTE));
    assign light_end = (count_reg == esfp_pkg::POS_LIGHT_SUM) &&
                       (type_reg == esfp_pkg::TYPE_LIGHT);
    assign env_end   = (count_reg == esfp_pkg::POS_ENV_SUM);
    assign in_data   = (count_reg >= esfp_pkg::POS_DATA_FIRST) &&
                       (count_reg <= esfp_pkg::POS_DATA_LAST);
    assign data_off  = count_reg - esfp_pkg::POS_DATA_FIRST;
    assign data_idx  = data_off[esfp_pkg::DATA_IDX_W-1:0];

    // The running sum covers every byte before the current one.
    assign push = accept && (sum_reg == rx_byte) &&
                  (light_end || (env_end && (type_reg == esfp_pkg::TYPE_ENV)));

    always_comb
    begin
        if (hdr_bad || light_end || env_end)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_reg + 1'b1;
        end
        if (count_reg == esfp_pkg::POS_HDR1)
        begin
            sum_next = rx_byte;
        end
        else
        begin
            sum_next = sum_reg + rx_byte;
        end
    end

    always_comb
    begin
        push_rec.kind = light_end ? esfp_pkg::KIND_LIGHT : esfp_pkg::KIND_ENV;
        for (int k = 0; k < esfp_pkg::DATA_BYTES; k++)
        begin
            push_rec.data[k] = data_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg <= sum_next;
            if (count_reg == esfp_pkg::POS_HDR1)
            begin
                byte0_reg <= rx_byte;
            end
            if (count_reg == esfp_pkg::POS_TYPE)
            begin
                type_reg <= rx_byte;
            end
            if (in_data)
            begin
                data_reg[data_idx] <= rx_byte;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= esfp_pkg::POS_ENV_SUM)
        else $error("frame byte count out of range");

    a_push_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((count_reg == esfp_pkg::POS_LIGHT_SUM) ||
                  (count_reg == esfp_pkg::POS_ENV_SUM)))
        else $error("frame pushed away from a checksum byte");

    a_hdr_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hdr_bad) |=> (count_reg == '0))
        else $error("bad header did not restart the frame");
`endif

endmodule

@@ rtl/core/esfp_queue.sv @@
// Short queue of checked frames between the front and the back.
module esfp_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  esfp_pkg::frame_rec_t push_rec,
    input  logic                 pop,
    output esfp_pkg::frame_rec_t pop_rec,
    output esfp_pkg::q_status_t  status
);

    esfp_pkg::frame_rec_t mem [esfp_pkg::Q_DEPTH];

    logic [esfp_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [esfp_pkg::Q_PTR_W-1:0] wr_ptr_next;
    logic [esfp_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [esfp_pkg::Q_PTR_W-1:0] rd_ptr_next;
    logic [esfp_pkg::Q_CNT_W-1:0] cnt_reg;
    logic [esfp_pkg::Q_CNT_W-1:0] cnt_next;

    assign status.full      = (cnt_reg == esfp_pkg::Q_CNT_W'(esfp_pkg::Q_DEPTH));
    assign status.not_empty = (cnt_reg != '0);
    assign pop_rec          = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == esfp_pkg::Q_PTR_W'(esfp_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == esfp_pkg::Q_PTR_W'(esfp_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !status.full)
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.not_empty)
        else $error("frame queue underflow");
`endif

endmodule

@@ rtl/core/esfp_back.sv @@
// Back part: turns a queued frame into result fields in an output register.
module esfp_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  esfp_pkg::q_status_t  q_status,
    input  esfp_pkg::frame_rec_t pop_rec,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic                 frame_kind,
    output logic [31:0]          light_hundredths,
    output logic [15:0]          temperature_hundredths,
    output logic [31:0]          pressure_hundredths,
    output logic [15:0]          humidity_hundredths,
    output logic [15:0]          altitude_m
);

    logic        valid_reg;
    logic        kind_reg;
    logic [31:0] light_reg;
    logic [15:0] temp_reg;
    logic [31:0] press_reg;
    logic [15:0] hum_reg;
    logic [15:0] alt_reg;
    logic        is_env;

    assign pop    = q_status.not_empty && (!valid_reg || !res_stall);
    assign is_env = (pop_rec.kind == esfp_pkg::KIND_ENV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Fields that do not belong to the frame kind are sent as zero.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= pop_rec.kind;
            light_reg <= is_env ? 32'd0 :
                         {pop_rec.data[0], pop_rec.data[1], pop_rec.data[2], pop_rec.data[3]};
            temp_reg  <= is_env ? {pop_rec.data[0], pop_rec.data[1]} : 16'd0;
            press_reg <= is_env ?
                         {pop_rec.data[2], pop_rec.data[3], pop_rec.data[4], pop_rec.data[5]} :
                         32'd0;
            hum_reg   <= is_env ? {pop_rec.data[6], pop_rec.data[7]} : 16'd0;
            alt_reg   <= is_env ? {pop_rec.data[8], pop_rec.data[9]} : 16'd0;
        end
    end

    assign res_valid              = valid_reg;
    assign frame_kind             = kind_reg;
    assign light_hundredths       = light_reg;
    assign temperature_hundredths = temp_reg;
    assign pressure_hundredths    = press_reg;
    assign humidity_hundredths    = hum_reg;
    assign altitude_m             = alt_reg;

`ifndef SYNTHESIS
    a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (kind_reg == esfp_pkg::KIND_LIGHT)) |->
        ((temp_reg == '0) && (press_reg == '0) && (hum_reg == '0) && (alt_reg == '0)))
        else $error("light result carries environment fields");
`endif

endmodule

@@ rtl/core/env_sensor_frame_parser.sv @@
// Top level of the environment sensor frame parser.
// The parser takes one received serial byte per item, one item per clock
// cycle, and gives one result item for each frame that passes its checks.
// A frame starts with two 0x5A header bytes; if either is wrong both are
// dropped and the next byte starts a new frame. The third byte is the type:
// 0x15 marks a 9-byte light frame, 0x45 a 15-byte environment frame, and any
// other type is thrown away at its fifteenth byte. The last byte of a frame
// is the 8-bit sum of all bytes before it, and a frame whose sum does not
// match gives no result. Result fields are the big-endian raw values of the
// frame, with the fields of the other frame kind set to zero. The front
// keeps a running sum, so the checksum byte is judged in the cycle it
// arrives; a good frame enters a two-entry queue at that edge and moves
// on into the output register once that register is empty or its result
// is being taken, and is held there as a result until it is taken. The
// input is stalled only while that queue is full, which needs the output
// to be held while two more frames arrive; with the output taking results
// freely the parser accepts a byte in every cycle.
module env_sensor_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        frame_kind,
    output logic [31:0] light_hundredths,
    output logic [15:0] temperature_hundredths,
    output logic [31:0] pressure_hundredths,
    output logic [15:0] humidity_hundredths,
    output logic [15:0] altitude_m
);

    esfp_pkg::q_status_t  q_status;
    esfp_pkg::frame_rec_t push_rec;
    esfp_pkg::frame_rec_t pop_rec;
    logic                 push;
    logic                 pop;

    // Byte capture and frame checks.
    esfp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_byte  (rx_byte),
        .q_status (q_status),
        .push     (push),
        .push_rec (push_rec)
    );

    // Decouples byte intake from a stalled result consumer.
    esfp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .status   (q_status)
    );

    // Field formatting and the result output register.
    esfp_back u_back
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .q_status               (q_status),
        .pop_rec                (pop_rec),
        .pop                    (pop),
        .res_valid              (res_valid),
        .res_stall              (res_stall),
        .frame_kind             (frame_kind),
        .light_hundredths       (light_hundredths),
        .temperature_hundredths (temperature_hundredths),
        .pressure_hundredths    (pressure_hundredths),
        .humidity_hundredths    (humidity_hundredths),
        .altitude_m             (altitude_m)
    );

endmodule
